[rtl/ppu_pkg.sv]
// Shared types, register indexes and lookup functions for the packed pixel unpacker.
`default_nettype none

package ppu_pkg;

    localparam logic [2:0] REG_UNIT_SIZE   = 3'd0;
    localparam logic [2:0] REG_ORDER_FLAGS = 3'd1;
    localparam logic [2:0] REG_PIXEL_BITS  = 3'd2;
    localparam logic [2:0] REG_LINE_PIXELS = 3'd3;
    localparam logic [2:0] REG_PAD_PIXELS  = 3'd4;
    localparam logic [2:0] REG_COLOR_MODE  = 3'd5;
    localparam logic [2:0] REG_COLOR_MASKS = 3'd6;

    localparam int CFG_DATA_W = 48;

    typedef struct packed {
        logic [1:0]  unit_size;
        logic [1:0]  order_flags;
        logic [5:0]  pixel_bits;
        logic [15:0] line_pixels;
        logic [15:0] pad_pixels;
        logic        color_mode;
        logic [47:0] color_masks;
    } ppu_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
    } ppu_unit_t;

    function automatic logic [5:0] unit_bits(input logic [1:0] unit_size);
        logic [5:0] bits;
        case (unit_size)
            2'd0:    bits = 6'd8;
            2'd1:    bits = 6'd16;
            default: bits = 6'd32;
        endcase
        return bits;
    endfunction

    // floor(32 / bpp); zero for bpp of zero or above 32
    function automatic logic [5:0] pixels_per_word(input logic [5:0] bpp);
        logic [5:0] n;
        if (bpp == 6'd0)       n = 6'd0;
        else if (bpp == 6'd1)  n = 6'd32;
        else if (bpp == 6'd2)  n = 6'd16;
        else if (bpp == 6'd3)  n = 6'd10;
        else if (bpp == 6'd4)  n = 6'd8;
        else if (bpp == 6'd5)  n = 6'd6;
        else if (bpp == 6'd6)  n = 6'd5;
        else if (bpp <= 6'd8)  n = 6'd4;
        else if (bpp <= 6'd10) n = 6'd3;
        else if (bpp <= 6'd16) n = 6'd2;
        else if (bpp <= 6'd32) n = 6'd1;
        else                   n = 6'd0;
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/ppu_cfg.sv]
// Configuration register file of the packed pixel unpacker.
`default_nettype none

module ppu_cfg
    import ppu_pkg::*;
#(
    parameter int COLUMN_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ppu_cfg_t              cfg
);

    localparam logic [15:0] LINE_MASK = (COLUMN_BITS >= 16) ? 16'hffff :
                                        16'((32'd1 << COLUMN_BITS) - 32'd1);

    ppu_cfg_t cfg_reg;
    ppu_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_UNIT_SIZE:   cfg_next.unit_size   = cfg_data[1:0];
                REG_ORDER_FLAGS: cfg_next.order_flags = cfg_data[1:0];
                REG_PIXEL_BITS:  cfg_next.pixel_bits  = cfg_data[5:0];
                REG_LINE_PIXELS: cfg_next.line_pixels = cfg_data[15:0] & LINE_MASK;
                REG_PAD_PIXELS:  cfg_next.pad_pixels  = cfg_data[15:0] & LINE_MASK;
                REG_COLOR_MODE:  cfg_next.color_mode  = cfg_data[0];
                REG_COLOR_MASKS: cfg_next.color_masks = cfg_data[47:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_size   <= 2'd0;
            cfg_reg.order_flags <= 2'd3;
            cfg_reg.pixel_bits  <= 6'd8;
            cfg_reg.line_pixels <= 16'd640;
            cfg_reg.pad_pixels  <= 16'd0;
            cfg_reg.color_mode  <= 1'b0;
            cfg_reg.color_masks <= 48'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/ppu_collect.sv]
// Byte collector: gathers raw bytes into one bitmap unit in either byte order.
`default_nettype none

module ppu_collect
    import ppu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ppu_cfg_t  cfg,
    input  logic [7:0] data_byte,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      load_ok,
    output ppu_unit_t unit
);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [2:0]  nbytes;
    logic        last_byte;
    logic        accept;
    logic [31:0] base;
    logic [31:0] assembled;

    always_comb
    begin
        case (cfg.unit_size)
            2'd0:    nbytes = 3'd1;
            2'd1:    nbytes = 3'd2;
            default: nbytes = 3'd4;
        endcase
    end

    assign last_byte = ({1'b0, count_reg} + 3'd1) >= nbytes;
    assign in_ready  = !last_byte || load_ok;
    assign accept    = in_valid && in_ready;
    assign base      = (count_reg == 2'd0) ? 32'd0 : word_reg;

    always_comb
    begin
        if (cfg.order_flags[0])
            assembled = {base[23:0], data_byte};
        else
            assembled = base | ({24'd0, data_byte} << {count_reg, 3'b000});
    end

    always_comb
    begin
        word_next  = word_reg;
        count_next = count_reg;
        if (accept)
        begin
            word_next  = assembled;
            count_next = last_byte ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= 32'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        unit.valid = accept && last_byte;
        case (cfg.unit_size)
            2'd0:    unit.word = {24'd0, assembled[7:0]};
            2'd1:    unit.word = {16'd0, assembled[15:0]};
            default: unit.word = assembled;
        endcase
    end

endmodule

`default_nettype wire

[rtl/ppu_emit.sv]
// Pixel emitter: walks a held unit one pixel per cycle unless output stalls, tracks the line column, drives results.
`default_nettype none

module ppu_emit
    import ppu_pkg::*;
#(
    parameter int COLUMN_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ppu_cfg_t    cfg,
    input  ppu_unit_t   unit,
    output logic        load_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_value,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        line_end,
    output logic        run_last,
    output logic        bad_format
);

    localparam int CW = COLUMN_BITS + 1;
    localparam int XW = (COLUMN_BITS + 2 > 18) ? COLUMN_BITS + 2 : 18;

    logic          busy_reg, busy_next;
    logic          bad_reg, bad_next;
    logic [31:0]   word_reg, word_next;
    logic [5:0]    pos_reg, pos_next;
    logic [4:0]    rem_reg, rem_next;
    logic [CW-1:0] column_reg, column_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   pixel_reg, pixel_next;
    logic [7:0]    red_reg, red_next;
    logic [7:0]    green_reg, green_next;
    logic [7:0]    blue_reg, blue_next;
    logic          line_end_reg, line_end_next;
    logic          run_last_reg, run_last_next;
    logic          bad_format_reg, bad_format_next;

    logic [5:0]    ubits;
    logic [5:0]    bpp;
    logic          ld_bad;
    logic [5:0]    ld_count;
    logic [5:0]    sh;
    logic [31:0]   pmask;
    logic [31:0]   pix;
    logic [31:0]   mred, mgreen, mblue;
    logic [XW-1:0] col_x, col1_x, line_x, total_x, rem_x;
    logic          visible;
    logic          more_visible;
    logic          out_free;
    logic          emit_now;
    logic          step;
    logic          fire;

    assign ubits = unit_bits(cfg.unit_size);
    assign bpp   = cfg.pixel_bits;

    assign ld_bad = (bpp == 6'd0) || (bpp > ubits) ||
                    (cfg.color_mode && bpp != 6'd16 && bpp != 6'd24 && bpp != 6'd32);

    always_comb
    begin
        case (cfg.unit_size)
            2'd0:    ld_count = pixels_per_word(bpp) >> 2;
            2'd1:    ld_count = pixels_per_word(bpp) >> 1;
            default: ld_count = pixels_per_word(bpp);
        endcase
    end

    assign sh    = cfg.order_flags[1] ? (ubits - bpp - pos_reg) : pos_reg;
    assign pmask = (bpp >= 6'd32) ? 32'hffff_ffff : ((32'd1 << bpp) - 32'd1);
    assign pix   = (word_reg >> sh) & pmask;
    assign mred   = pix & {16'd0, cfg.color_masks[15:0]};
    assign mgreen = (pix & {16'd0, cfg.color_masks[31:16]}) >> 5;
    assign mblue  = (pix & {16'd0, cfg.color_masks[47:32]}) >> 10;

    assign col_x   = XW'(column_reg);
    assign col1_x  = col_x + XW'(1);
    assign line_x  = XW'(cfg.line_pixels);
    assign total_x = XW'(cfg.line_pixels) + XW'(cfg.pad_pixels);
    assign rem_x   = XW'(rem_reg);

    assign visible = col_x < line_x;
    // another pixel of this unit lands in the visible part of a line
    assign more_visible = (rem_reg != 5'd0) && (cfg.line_pixels != 16'd0) &&
                          ((col1_x < line_x) || (col1_x >= total_x) ||
                           ((total_x - col_x) <= rem_x));

    assign out_free = !out_valid_reg || out_ready;
    assign emit_now = bad_reg || visible;
    assign step     = busy_reg && (!emit_now || out_free);
    assign fire     = step && emit_now;
    assign load_ok  = !busy_reg || (step && rem_reg == 5'd0);

    always_comb
    begin
        busy_next   = busy_reg;
        bad_next    = bad_reg;
        word_next   = word_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        column_next = column_reg;

        if (step)
        begin
            if (rem_reg == 5'd0)
                busy_next = 1'b0;
            rem_next = rem_reg - 5'd1;
            pos_next = pos_reg + bpp;
            if (!bad_reg)
                column_next = (col1_x >= total_x) ? '0 : CW'(col1_x);
        end

        if (unit.valid)
        begin
            busy_next = 1'b1;
            bad_next  = ld_bad;
            word_next = unit.word;
            pos_next  = 6'd0;
            rem_next  = ld_bad ? 5'd0 : 5'(ld_count - 6'd1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_next      = pixel_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        line_end_next   = line_end_reg;
        run_last_next   = run_last_reg;
        bad_format_next = bad_format_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            if (bad_reg)
            begin
                pixel_next      = 32'd0;
                red_next        = 8'd0;
                green_next      = 8'd0;
                blue_next       = 8'd0;
                line_end_next   = 1'b0;
                run_last_next   = 1'b1;
                bad_format_next = 1'b1;
            end
            else
            begin
                pixel_next      = pix;
                red_next        = 8'd0;
                green_next      = 8'd0;
                blue_next       = 8'd0;
                if (cfg.color_mode)
                begin
                    if (bpp == 6'd16)
                    begin
                        red_next   = mred[7:0];
                        green_next = mgreen[7:0];
                        blue_next  = mblue[7:0];
                    end
                    else
                    begin
                        red_next   = pix[7:0];
                        green_next = pix[15:8];
                        blue_next  = pix[23:16];
                    end
                end
                line_end_next   = col1_x == line_x;
                run_last_next   = !more_visible;
                bad_format_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            rem_reg       <= 5'd0;
            pos_reg       <= 6'd0;
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            bad_reg       <= bad_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        pixel_reg      <= pixel_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        line_end_reg   <= line_end_next;
        run_last_reg   <= run_last_next;
        bad_format_reg <= bad_format_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign line_end    = line_end_reg;
    assign run_last    = run_last_reg;
    assign bad_format  = bad_format_reg;

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_format_reg |-> run_last_reg)
        else $error("error result without run_last");

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && bad_reg |-> rem_reg == 5'd0)
        else $error("bad unit holds more than one step");

    a_column_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> $stable(column_reg))
        else $error("column moved while no unit held");

    a_unit_taken: assert property (@(posedge clk) disable iff (!rst_n)
        unit.valid |-> load_ok)
        else $error("unit handed over while emitter full");

endmodule

`default_nettype wire

[rtl/packed_pixel_unpacker.sv]
// Top level of the packed pixel unpacker.
// Takes one raw image byte per transaction and returns one transaction per visible
// pixel, or a single error transaction per unit of bad format. Bytes are taken one
// per cycle while a bitmap unit is being collected; the completed unit moves into
// the emitter, which steps through its pixels one per cycle unless stalled, pad
// pixels included, but drives out only the visible ones. The byte that completes a
// unit waits only while the emitter is still on the previous unit.
// A visible pixel is produced only when the result register is empty or being taken,
// so output back-pressure stalls the emitter and, through it, the byte that completes
// the next unit; with out_ready held high the output never stalls the emitter.
`default_nettype none

module packed_pixel_unpacker
    import ppu_pkg::*;
#(
    parameter int COLUMN_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           pixel_value,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  line_end,
    output logic                  run_last,
    output logic                  bad_format
);

    ppu_cfg_t  cfg;
    ppu_unit_t unit;
    logic      load_ok;

    ppu_cfg #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppu_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .data_byte (data_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .load_ok   (load_ok),
        .unit      (unit)
    );

    ppu_emit #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .unit        (unit),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_value (pixel_value),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .line_end    (line_end),
        .run_last    (run_last),
        .bad_format  (bad_format)
    );

endmodule

`default_nettype wire
